// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the timecode parser.
// Depends on nothing; the file that includes it supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge while reset is released.
`define TC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("timecode parser assertion failed");

// Checked on every clock edge, also during reset.
`define TC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("timecode parser assertion failed");

`else

`define TC_ASSERT(label, prop)
`define TC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hw/rtl/tctms_pkg.sv =====
// Types and constants of the timecode parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tctms_pkg;

	// Operations that the front hands to the back.
	typedef enum logic [1:0] {
		OP_DIGIT,
		OP_COLON,
		OP_POINT,
		OP_END
	} op_code_t;

	// One queued operation; digit is meaningful for OP_DIGIT only.
	typedef struct packed {
		op_code_t   code;
		logic [3:0] digit;
	} op_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_RUN,
		BK_SCALE_PT,
		BK_SCALE_END
	} back_state_t;

	// Characters with a meaning.
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_PERIOD = 8'h2E;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	// Largest time that can be reported, in milliseconds.
	localparam logic [30:0] MAX_TIME_MS = 31'd2145599994;

	// Fraction weight codes: none seen, and digits that no longer count.
	localparam logic [2:0] FW_NONE = 3'd0;
	localparam logic [2:0] FW_ZERO = 3'd4;

endpackage

// ===== hw/rtl/timecode_text_to_milliseconds.sv =====
// Timecode text parser: characters in, one millisecond time per text out.
// Throughput: one character per cycle while item_stall is low; a point or an end of text
// without one adds a scale step in the back end.
// An end-of-text request passes the front stage, the queue and the result register before
// its result shows; without a point, the scale step comes in between as well.
// Reset clears the queue, the time state and the result valid flag at once.
`include "assert_macros.svh"

module timecode_text_to_milliseconds #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  character,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [30:0] time_ms
);
	import tctms_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             push;
	op_t              push_op;
	logic             queue_full;
	logic             pop;
	op_t              head_op;
	logic             head_valid;
	logic [CNT_W-1:0] queue_count;

	tctms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.character  (character),
		.push       (push),
		.push_op    (push_op),
		.queue_full (queue_full)
	);

	tctms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head_op    (head_op),
		.head_valid (head_valid),
		.full       (queue_full),
		.count      (queue_count)
	);

	tctms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_op      (head_op),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.time_ms      (time_ms)
	);

	// The back never takes from an empty queue, and the queue never overfills.
	`TC_ASSERT(a_pop_nonempty, pop |-> queue_count != '0)
	`TC_ASSERT(a_count_bound, queue_count <= CNT_W'(QUEUE_DEPTH))
	// A full queue pushes back on the front.
	`TC_ASSERT(a_full_no_push, queue_full |-> !push)
	// A shown result is always within the reportable range.
	`TC_ASSERT(a_result_range, result_valid |-> time_ms <= MAX_TIME_MS)

endmodule

// ===== hw/rtl/tctms_front.sv =====
// Front end of the timecode parser: accepts requests and classifies them.
// Depends on tctms_pkg; feeds the operation queue.
module tctms_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic            kind,
	input  logic [7:0]      character,
	output logic            push,
	output tctms_pkg::op_t  push_op,
	input  logic            queue_full
);
	import tctms_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_class;
	logic keep;
	logic accept;

	// Classify the incoming request; bytes without a meaning are dropped.
	always_comb begin
		op_class.code  = OP_END;
		op_class.digit = 4'd0;
		keep           = 1'b1;
		if (kind) begin
			op_class.code = OP_END;
		end else if (character == CHAR_COLON) begin
			op_class.code = OP_COLON;
		end else if (character == CHAR_PERIOD || character == CHAR_COMMA) begin
			op_class.code = OP_POINT;
		end else if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
			op_class.code  = OP_DIGIT;
			op_class.digit = 4'(character - CHAR_ZERO);
		end else begin
			keep = 1'b0;
		end
	end

	// The stage holds one operation until the queue takes it.
	assign push       = valid_s1 && !queue_full;
	assign push_op    = op_s1;
	assign item_stall = valid_s1 && queue_full;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && keep) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			op_s1 <= op_class;
		end
	end

endmodule

// ===== hw/rtl/tctms_queue.sv =====
// Short operation queue between the front and the back of the parser.
// Depends on tctms_pkg for the operation type.
module tctms_queue #(
	parameter int DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  tctms_pkg::op_t                push_op,
	input  logic                          pop,
	output tctms_pkg::op_t                head_op,
	output logic                          head_valid,
	output logic                          full,
	output logic [$clog2(DEPTH + 1)-1:0]  count
);
	import tctms_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_op    = slots_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign count      = count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== hw/rtl/tctms_back.sv =====
// Back end of the timecode parser: runs queued operations on the time state.
// Depends on tctms_pkg; drives the registered result port.
module tctms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tctms_pkg::op_t  head_op,
	input  logic            head_valid,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [30:0]     time_ms
);
	import tctms_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] acc_q;
	logic [31:0] acc_d;
	logic [31:0] group_q;
	logic [31:0] group_d;
	logic [2:0]  fw_q;
	logic [2:0]  fw_d;
	logic        res_valid_q;
	logic [30:0] res_time_q;
	logic        emit;
	logic [31:0] emit_time;
	logic        out_free;

	logic [38:0] fold_sum;
	logic [31:0] fold_sat;
	logic [41:0] scale_prod;
	logic [31:0] scale_sat;
	logic [35:0] group_sum;
	logic [31:0] group_sat;
	logic [9:0]  weight;
	logic [9:0]  frac_term;
	logic [32:0] frac_sum;
	logic [31:0] frac_sat;

	// Saturating base-60 fold, millisecond scaling, digit accumulation.
	always_comb begin
		fold_sum   = {7'd0, acc_q} * 39'd60 + {7'd0, group_q};
		fold_sat   = (|fold_sum[38:32]) ? '1 : fold_sum[31:0];
		scale_prod = {10'd0, acc_q} * 42'd1000;
		scale_sat  = (|scale_prod[41:32]) ? '1 : scale_prod[31:0];
		group_sum  = {4'd0, group_q} * 36'd10 + {32'd0, head_op.digit};
		group_sat  = (|group_sum[35:32]) ? '1 : group_sum[31:0];
		unique case (fw_q)
			3'd1:    weight = 10'd100;
			3'd2:    weight = 10'd10;
			3'd3:    weight = 10'd1;
			default: weight = 10'd0;
		endcase
		frac_term = {6'd0, head_op.digit} * weight;
		frac_sum  = {1'b0, acc_q} + {23'd0, frac_term};
		frac_sat  = frac_sum[32] ? '1 : frac_sum[31:0];
	end

	assign out_free = !res_valid_q || !result_stall;

	// Sequencer: next state and state updates.
	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		group_d   = group_q;
		fw_d      = fw_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_time = acc_q;
		unique case (state_q)
			BK_RUN: begin
				if (head_valid) begin
					unique case (head_op.code)
						OP_DIGIT: begin
							pop = 1'b1;
							if (fw_q == FW_NONE) begin
								group_d = group_sat;
							end else begin
								acc_d = frac_sat;
								if (fw_q < FW_ZERO) begin
									fw_d = fw_q + 3'd1;
								end
							end
						end
						OP_COLON: begin
							pop     = 1'b1;
							acc_d   = fold_sat;
							group_d = '0;
						end
						OP_POINT: begin
							pop     = 1'b1;
							acc_d   = fold_sat;
							state_d = BK_SCALE_PT;
						end
						OP_END: begin
							if (fw_q == FW_NONE) begin
								pop     = 1'b1;
								acc_d   = fold_sat;
								state_d = BK_SCALE_END;
							end else if (out_free) begin
								pop       = 1'b1;
								emit      = 1'b1;
								emit_time = acc_q;
								acc_d     = '0;
								group_d   = '0;
								fw_d      = FW_NONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_SCALE_PT: begin
				acc_d   = scale_sat;
				group_d = '0;
				fw_d    = 3'd1;
				state_d = BK_RUN;
			end
			BK_SCALE_END: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_time = scale_sat;
					acc_d     = '0;
					group_d   = '0;
					fw_d      = FW_NONE;
					state_d   = BK_RUN;
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			acc_q       <= '0;
			group_q     <= '0;
			fw_q        <= FW_NONE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			group_q <= group_d;
			fw_q    <= fw_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register, clamped to the largest reportable time.
	always_ff @(posedge clk) begin
		if (emit) begin
			res_time_q <= (emit_time > {1'b0, MAX_TIME_MS}) ? MAX_TIME_MS : emit_time[30:0];
		end
	end

	assign result_valid = res_valid_q;
	assign time_ms      = res_time_q;

endmodule

// ===== verif/timecode_text_to_milliseconds_tb.sv =====
// Self-checking testbench for the timecode text parser: text requests in, millisecond times out.
// Depends on tctms_pkg and the timecode_text_to_milliseconds top level; needs nothing else.
// A local predictor tracks the parse state and every result is checked against it in order.
module timecode_text_to_milliseconds_tb;
	import tctms_pkg::*;

	// Request kinds.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Fraction weight codes for the first three digits after a point.
	localparam logic [2:0] FW_TENTHS      = 3'd1;
	localparam logic [2:0] FW_HUNDREDTHS  = 3'd2;
	localparam logic [2:0] FW_THOUSANDTHS = 3'd3;

	localparam int RANDOM_PER_PHASE = 380;
	localparam int SETTLE_CYCLES    = 10;
	localparam int REPORT_LIMIT     = 50;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
	} text_req_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        kind;
	logic [7:0]  character;
	logic        result_valid;
	logic        result_stall;
	logic [30:0] time_ms;

	timecode_text_to_milliseconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.character    (character),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.time_ms      (time_ms)
	);

	// Requests waiting to be driven, and times the parser still owes.
	text_req_t   pending_reqs[$];
	logic [30:0] expected_times[$];

	// Predicted parse state.
	logic [31:0] acc_time = '0;
	logic [31:0] group_val = '0;
	logic [2:0]  frac_weight = FW_NONE;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int queued_count = 0;
	int accepted_count = 0;
	int results_checked = 0;
	int error_count = 0;
	int phase_items = 0;
	logic took_item = 1'b0;

	// Saturating a * m + b on 32 bits.
	function automatic logic [31:0] sat_mac(input logic [31:0] a, input logic [31:0] m,
			input logic [31:0] b);
		logic [63:0] r;
		r = {32'd0, a} * {32'd0, m} + {32'd0, b};
		return (r > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	// Advance the predicted state by one accepted request.
	task automatic predict_timecode(input logic k, input logic [7:0] ch);
		logic [31:0] t;
		logic [31:0] d;
		logic [31:0] w;
		if (k == KIND_END) begin
			t = acc_time;
			if (frac_weight == FW_NONE)
				t = sat_mac(sat_mac(acc_time, 32'd60, group_val), 32'd1000, 32'd0);
			if (t > {1'b0, MAX_TIME_MS})
				t = {1'b0, MAX_TIME_MS};
			expected_times.push_back(t[30:0]);
			acc_time = '0;
			group_val = '0;
			frac_weight = FW_NONE;
		end else if (ch == CHAR_COLON) begin
			acc_time = sat_mac(acc_time, 32'd60, group_val);
			group_val = '0;
		end else if (ch == CHAR_PERIOD || ch == CHAR_COMMA) begin
			acc_time = sat_mac(sat_mac(acc_time, 32'd60, group_val), 32'd1000, 32'd0);
			group_val = '0;
			frac_weight = FW_TENTHS;
		end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			d = {24'd0, ch - CHAR_ZERO};
			if (frac_weight == FW_NONE) begin
				group_val = sat_mac(group_val, 32'd10, d);
			end else begin
				case (frac_weight)
					FW_TENTHS:      w = 32'd100;
					FW_HUNDREDTHS:  w = 32'd10;
					FW_THOUSANDTHS: w = 32'd1;
					default:        w = 32'd0;
				endcase
				acc_time = sat_mac(d, w, acc_time);
				if (frac_weight < FW_ZERO)
					frac_weight = frac_weight + 3'd1;
			end
		end
	endtask

	// Queue one request; every request counts toward the phase size.
	task automatic push_req(input logic k, input logic [7:0] ch);
		text_req_t r;
		r.kind = k;
		r.ch = ch;
		pending_reqs.push_back(r);
		queued_count++;
		phase_items++;
	endtask

	task automatic push_digits(input int n);
		for (int i = 0; i < n; i++)
			push_req(KIND_CHAR, CHAR_ZERO + 8'($urandom_range(9)));
	endtask

	// End of text carries a random byte that the parser must ignore.
	task automatic push_end();
		push_req(KIND_END, 8'($urandom_range(255)));
	endtask

	// One random text: mostly well-formed stamps, plus long, noisy and broken ones.
	task automatic add_random_text();
		int sel;
		int n;
		int pick;
		sel = $urandom_range(99);
		if (sel < 60) begin
			n = $urandom_range(3);
			if (n != 0) begin
				push_digits(n);
				push_req(KIND_CHAR, CHAR_COLON);
			end
			if ($urandom_range(99) < 70) begin
				push_digits(2);
				push_req(KIND_CHAR, CHAR_COLON);
			end
			push_digits($urandom_range(1, 2));
			if ($urandom_range(99) < 80) begin
				push_req(KIND_CHAR, ($urandom_range(1) != 0) ? CHAR_PERIOD : CHAR_COMMA);
				push_digits($urandom_range(4));
			end
		end else if (sel < 75) begin
			// Long digit runs drive the sums into saturation and the clamp.
			push_digits($urandom_range(6, 14));
			if ($urandom_range(1) != 0) begin
				push_req(KIND_CHAR, CHAR_COLON);
				push_digits($urandom_range(1, 8));
			end
			if ($urandom_range(1) != 0) begin
				push_req(KIND_CHAR, CHAR_PERIOD);
				push_digits($urandom_range(4));
			end
		end else if (sel < 88) begin
			n = $urandom_range(8);
			for (int i = 0; i < n; i++)
				push_req(KIND_CHAR, 8'($urandom_range(255)));
		end else begin
			// Broken text: points repeated, colons after a point, stray bytes.
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(9);
				case (pick)
					0: push_req(KIND_CHAR, CHAR_COLON);
					1: push_req(KIND_CHAR, CHAR_PERIOD);
					2: push_req(KIND_CHAR, CHAR_COMMA);
					3: push_req(KIND_CHAR, 8'($urandom_range(255)));
					default: push_digits(1);
				endcase
			end
		end
		push_end();
	endtask

	// Hold the sender until everything sent has been accepted and answered.
	task automatic drain_parser();
		@(negedge clk);
		while (accepted_count != queued_count || expected_times.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Request driver: presents the next request at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			result_stall <= 1'b0;
		end else begin
			if (!item_valid || took_item) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					kind <= pending_reqs[0].kind;
					character <= pending_reqs[0].ch;
					pending_reqs.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: predicts on accepted requests and checks accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			took_item <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				accepted_count++;
				predict_timecode(kind, character);
			end
			if (result_valid && !result_stall) begin
				if (expected_times.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: unexpected result, expected none, got time_ms %0d",
							$time, time_ms);
				end else begin
					if (time_ms !== expected_times[0]) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display("%0t: time_ms mismatch, expected %0d, got %0d",
								$time, expected_times[0], time_ms);
					end
					expected_times.pop_front();
					results_checked++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		kind = KIND_CHAR;
		character = 8'h00;
		result_stall = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty text with a byte on the end request.
		push_req(KIND_END, 8'hFF);
		// Colon, comma, ignored bytes at both ends of the range, digits past the third.
		push_req(KIND_CHAR, CHAR_ZERO + 8'd1);
		push_req(KIND_CHAR, CHAR_COLON);
		push_req(KIND_CHAR, 8'h00);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd2);
		push_req(KIND_CHAR, CHAR_COMMA);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd3);
		push_req(KIND_CHAR, 8'hFF);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd4);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd5);
		push_req(KIND_CHAR, CHAR_NINE);
		push_req(KIND_END, 8'h00);
		// Repeated period, then a colon after the point.
		push_req(KIND_CHAR, CHAR_ZERO + 8'd5);
		push_req(KIND_CHAR, CHAR_PERIOD);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd1);
		push_req(KIND_CHAR, CHAR_PERIOD);
		push_req(KIND_CHAR, CHAR_ZERO + 8'd2);
		push_req(KIND_CHAR, CHAR_COLON);
		push_req(KIND_CHAR, CHAR_ZERO);
		push_req(KIND_END, CHAR_COLON);
		// A long run of nines overflows the scale and hits the clamp.
		for (int i = 0; i < 7; i++)
			push_req(KIND_CHAR, CHAR_NINE);
		push_req(KIND_END, CHAR_PERIOD);

		// Four idle and stall mixes, each drained before the next starts.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			phase_items = 0;
			while (phase_items < RANDOM_PER_PHASE)
				add_random_text();
			drain_parser();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_times.size() != 0) begin
			error_count++;
			$display("%0t: results missing, expected %0d more, got none", $time,
				expected_times.size());
		end
		$display("Checked %0d parsed times from %0d accepted requests,", results_checked,
			accepted_count);
		$display("across free-running, sender-idle, receiver-stall and mixed traffic.");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(12 * 200000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
